// ----- rtl/rvdx_pkg.sv -----
// shared types, opcodes and function codes for the decode/execute unit
package rvdx_pkg;

    localparam int unsigned XLEN = 32;
    localparam int unsigned DIV_STAGES = 32;

    localparam logic [6:0] OPC_REG    = 7'b0110011;
    localparam logic [6:0] OPC_IMM    = 7'b0010011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] F7_BASE    = 7'b0000000;
    localparam logic [6:0] F7_ALT     = 7'b0100000;
    localparam logic [6:0] F7_MULDIV  = 7'b0000001;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SRL  = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;

    typedef enum logic [1:0] {
        WB_NONE = 2'd0,
        WB_ALU  = 2'd1,
        WB_LOAD = 2'd2,
        WB_RET  = 2'd3
    } wb_src_t;

    // how the final stage picks the writeback value
    typedef enum logic [1:0] {
        RES_EARLY = 2'd0,
        RES_MUL   = 2'd1,
        RES_DIV   = 2'd2,
        RES_REM   = 2'd3
    } res_sel_t;

    // decoded result fields that ride along with the divider
    typedef struct packed {
        logic             illegal;
        logic [4:0]       dest_index;
        wb_src_t          wb_source;
        logic [XLEN-1:0]  wb_value;
        logic             mem_enable;
        logic             mem_is_load;
        logic [1:0]       mem_size_code;
        logic [XLEN-1:0]  mem_address;
        logic [XLEN-1:0]  store_data;
        logic             branch_taken;
        logic [XLEN-1:0]  next_pc;
        res_sel_t         res_sel;
        logic             neg_q;
        logic             neg_r;
        logic             div_zero;
    } rec_t;

endpackage

// ----- rtl/rv32_subset_decode_execute_unit.sv -----
// top level: decode/execute for an rv32im subset, deep pipeline
//
//  channel | valid     | stall     | fields
//  in      | in_valid  | in_stall  | instr_word cur_pc src1_value src2_value
//  out     | out_valid | out_stall | illegal .. next_pc
//
// one word per cycle unless the output stalls; pipeline: decode, operand prep
// with the multiply, a 32-stage restoring divider (one quotient bit per
// stage) and an output register. every instruction passes the same path.
// the whole pipe advances when the output register is free or being taken.
// reset clears valid bits only.
module rv32_subset_decode_execute_unit
    import rvdx_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        instr_word,
    input  logic [31:0]        cur_pc,
    input  logic signed [31:0] src1_value,
    input  logic signed [31:0] src2_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               illegal,
    output logic [4:0]         dest_index,
    output logic [1:0]         wb_source,
    output logic [31:0]        wb_value,
    output logic               mem_enable,
    output logic               mem_is_load,
    output logic [1:0]         mem_size_code,
    output logic [31:0]        mem_address,
    output logic [31:0]        store_data,
    output logic               branch_taken,
    output logic [31:0]        next_pc
);

    logic adv;
    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    // stage 1: decode and simple results
    logic [6:0]  opc, f7;
    logic [2:0]  f3;
    logic [31:0] a, b, imm_i, imm_s, imm_b, imm_j, imm_u, pc4;
    logic [4:0]  sh;
    logic        lts;
    rec_t        dec;

    always_comb
    begin
        a     = src1_value;
        b     = src2_value;
        opc   = instr_word[6:0];
        f3    = instr_word[14:12];
        f7    = instr_word[31:25];
        imm_i = {{20{instr_word[31]}}, instr_word[31:20]};
        imm_s = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
        imm_b = {{20{instr_word[31]}}, instr_word[7], instr_word[30:25],
                 instr_word[11:8], 1'b0};
        imm_j = {{12{instr_word[31]}}, instr_word[19:12], instr_word[20],
                 instr_word[30:21], 1'b0};
        imm_u = {instr_word[31:12], 12'd0};
        pc4   = cur_pc + 32'd4;
        sh    = b[4:0];
        lts   = $signed(a) < $signed(b);

        dec = '0;
        dec.wb_source = WB_NONE;
        dec.res_sel   = RES_EARLY;
        dec.next_pc   = pc4;
        dec.neg_q     = a[31] ^ b[31];
        dec.neg_r     = a[31];
        dec.div_zero  = (b == 32'd0);

        case (opc)
            OPC_REG:
            begin
                dec.dest_index = instr_word[11:7];
                dec.wb_source  = WB_ALU;
                if (f7 == F7_BASE)
                begin
                    case (f3)
                        F3_ADD:  dec.wb_value = a + b;
                        F3_SLL:  dec.wb_value = a << sh;
                        F3_SLT:  dec.wb_value = {31'd0, lts};
                        F3_XOR:  dec.wb_value = a ^ b;
                        F3_SRL:  dec.wb_value = a >> sh;
                        F3_OR:   dec.wb_value = a | b;
                        F3_AND:  dec.wb_value = a & b;
                        default: dec.illegal = 1'b1;
                    endcase
                end
                else if (f7 == F7_ALT)
                begin
                    if (f3 == F3_ADD)
                        dec.wb_value = a - b;
                    else if (f3 == F3_SRL)
                        dec.wb_value = 32'($signed(a) >>> sh);
                    else
                        dec.illegal = 1'b1;
                end
                else if (f7 == F7_MULDIV)
                begin
                    if (f3 == F3_ADD)
                        dec.res_sel = RES_MUL;
                    else if (f3 == F3_XOR)
                        dec.res_sel = RES_DIV;
                    else if (f3 == F3_OR)
                        dec.res_sel = RES_REM;
                    else
                        dec.illegal = 1'b1;
                end
                else
                    dec.illegal = 1'b1;
            end
            OPC_IMM:
            begin
                dec.dest_index = instr_word[11:7];
                dec.wb_source  = WB_ALU;
                if (f3 == F3_ADD)
                    dec.wb_value = a + imm_i;
                else if (f3 == F3_AND)
                    dec.wb_value = a & imm_i;
                else if (f3 == F3_OR)
                    dec.wb_value = a | imm_i;
                else
                    dec.illegal = 1'b1;
            end
            OPC_LOAD:
            begin
                if (!f3[2])
                begin
                    dec.dest_index    = instr_word[11:7];
                    dec.wb_source     = WB_LOAD;
                    dec.mem_enable    = 1'b1;
                    dec.mem_is_load   = 1'b1;
                    dec.mem_size_code = f3[1:0];
                    dec.mem_address   = a + imm_i;
                end
                else
                    dec.illegal = 1'b1;
            end
            OPC_STORE:
            begin
                if (!f3[2])
                begin
                    dec.mem_enable    = 1'b1;
                    dec.mem_size_code = f3[1:0];
                    dec.mem_address   = a + imm_s;
                    dec.store_data    = b;
                end
                else
                    dec.illegal = 1'b1;
            end
            OPC_JALR:
            begin
                if (f3 == F3_ADD)
                begin
                    dec.dest_index = instr_word[11:7];
                    dec.wb_source  = WB_RET;
                    dec.wb_value   = pc4;
                    dec.next_pc    = (a + imm_i) & ~32'd1;
                end
                else
                    dec.illegal = 1'b1;
            end
            OPC_BRANCH:
            begin
                case (f3)
                    F3_BEQ:  dec.branch_taken = (a == b);
                    F3_BNE:  dec.branch_taken = (a != b);
                    F3_BGE:  dec.branch_taken = !lts;
                    F3_BLT:  dec.branch_taken = lts;
                    default: dec.illegal = 1'b1;
                endcase
                if (dec.branch_taken)
                    dec.next_pc = cur_pc + imm_b;
            end
            OPC_AUIPC:
            begin
                dec.dest_index = instr_word[11:7];
                dec.wb_source  = WB_RET;
                dec.wb_value   = cur_pc + imm_u;
            end
            OPC_LUI:
            begin
                dec.dest_index = instr_word[11:7];
                dec.wb_source  = WB_ALU;
                dec.wb_value   = imm_u;
            end
            OPC_JAL:
            begin
                dec.dest_index = instr_word[11:7];
                dec.wb_source  = WB_RET;
                dec.wb_value   = pc4;
                dec.next_pc    = cur_pc + imm_j;
            end
            default: dec.illegal = 1'b1;
        endcase

        if (dec.illegal)
        begin
            dec         = '0;
            dec.illegal = 1'b1;
            dec.next_pc = pc4;
            dec.wb_source = WB_NONE;
            dec.res_sel = RES_EARLY;
        end
    end

    logic        s1_vld_reg;
    rec_t        s1_rec_reg;
    logic [31:0] s1_a_reg, s1_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (adv)
            s1_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_rec_reg <= dec;
            s1_a_reg   <= a;
            s1_b_reg   <= b;
        end
    end

    // stage 2: magnitudes for the divider, product for mul
    logic [31:0] ua, ub, prod;
    always_comb
    begin
        ua   = s1_a_reg[31] ? 32'd0 - s1_a_reg : s1_a_reg;
        ub   = s1_b_reg[31] ? 32'd0 - s1_b_reg : s1_b_reg;
        prod = s1_a_reg * s1_b_reg;
    end

    rec_t        s2_rec_next;
    logic        s2_vld_reg;
    rec_t        s2_rec_reg;
    logic [31:0] s2_ua_reg, s2_ub_reg;

    always_comb
    begin
        s2_rec_next = s1_rec_reg;
        if (s1_rec_reg.res_sel == RES_MUL)
            s2_rec_next.wb_value = prod;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (adv)
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_rec_reg <= s2_rec_next;
            s2_ua_reg  <= ua;
            s2_ub_reg  <= ub;
        end
    end

    logic        dv_vld;
    logic [31:0] dv_q, dv_r;
    rec_t        dv_rec;

    rvdx_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s2_vld_reg),
        .dividend  (s2_ua_reg),
        .divisor   (s2_ub_reg),
        .in_rec    (s2_rec_reg),
        .out_valid (dv_vld),
        .quotient  (dv_q),
        .remainder (dv_r),
        .out_rec   (dv_rec)
    );

    // final stage: sign fixup and select
    logic [31:0] wb_next;
    always_comb
    begin
        case (dv_rec.res_sel)
            RES_DIV: wb_next = dv_rec.div_zero ? 32'd0 :
                               (dv_rec.neg_q ? 32'd0 - dv_q : dv_q);
            RES_REM: wb_next = dv_rec.div_zero ? 32'd0 :
                               (dv_rec.neg_r ? 32'd0 - dv_r : dv_r);
            default: wb_next = dv_rec.wb_value;
        endcase
    end

    logic out_vld_reg;
    rec_t out_rec_reg;
    logic [31:0] out_wb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= dv_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_rec_reg <= dv_rec;
            out_wb_reg  <= wb_next;
        end
    end

    assign out_valid     = out_vld_reg;
    assign illegal       = out_rec_reg.illegal;
    assign dest_index    = out_rec_reg.dest_index;
    assign wb_source     = out_rec_reg.wb_source;
    assign wb_value      = out_wb_reg;
    assign mem_enable    = out_rec_reg.mem_enable;
    assign mem_is_load   = out_rec_reg.mem_is_load;
    assign mem_size_code = out_rec_reg.mem_size_code;
    assign mem_address   = out_rec_reg.mem_address;
    assign store_data    = out_rec_reg.store_data;
    assign branch_taken  = out_rec_reg.branch_taken;
    assign next_pc       = out_rec_reg.next_pc;

endmodule

// ----- rtl/rvdx_div_pipe.sv -----
// pipelined unsigned divider with side record, one quotient bit per stage
module rvdx_div_pipe
    import rvdx_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  logic [XLEN-1:0] dividend,
    input  logic [XLEN-1:0] divisor,
    input  rec_t            in_rec,
    output logic            out_valid,
    output logic [XLEN-1:0] quotient,
    output logic [XLEN-1:0] remainder,
    output rec_t            out_rec
);

    // entry g holds the state after stage g
    logic                  vld_reg [DIV_STAGES];
    logic [XLEN-1:0]       q_reg   [DIV_STAGES];
    logic [XLEN-1:0]       r_reg   [DIV_STAGES];
    logic [XLEN-1:0]       d_reg   [DIV_STAGES];
    rec_t                  rec_reg [DIV_STAGES];

    genvar g;
    generate
        for (g = 0; g < DIV_STAGES; g++)
        begin : g_stage
            logic            vld_in;
            logic [XLEN-1:0] q_in;
            logic [XLEN-1:0] r_in;
            logic [XLEN-1:0] d_in;
            rec_t            rec_in;
            logic [XLEN:0]   trial;
            logic [XLEN:0]   shifted;

            if (g == 0)
            begin : g_first
                assign vld_in = in_valid;
                assign q_in   = dividend;
                assign r_in   = '0;
                assign d_in   = divisor;
                assign rec_in = in_rec;
            end
            else
            begin : g_next
                assign vld_in = vld_reg[g-1];
                assign q_in   = q_reg[g-1];
                assign r_in   = r_reg[g-1];
                assign d_in   = d_reg[g-1];
                assign rec_in = rec_reg[g-1];
            end

            assign shifted = {r_in, q_in[XLEN-1]};
            assign trial   = shifted - {1'b0, d_in};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[g] <= 1'b0;
                else if (adv)
                    vld_reg[g] <= vld_in;
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    d_reg[g]   <= d_in;
                    rec_reg[g] <= rec_in;
                    if (!trial[XLEN])
                    begin
                        r_reg[g] <= trial[XLEN-1:0];
                        q_reg[g] <= {q_in[XLEN-2:0], 1'b1};
                    end
                    else
                    begin
                        r_reg[g] <= shifted[XLEN-1:0];
                        q_reg[g] <= {q_in[XLEN-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[DIV_STAGES-1];
    assign quotient  = q_reg[DIV_STAGES-1];
    assign remainder = r_reg[DIV_STAGES-1];
    assign out_rec   = rec_reg[DIV_STAGES-1];

endmodule

// ----- test/tb_rv32_subset_decode_execute_unit.sv -----
// testbench for the rv32 subset decode/execute unit: predicted results checked per word
module tb_rv32_subset_decode_execute_unit
    import rvdx_pkg::*;
();

    typedef struct packed {
        logic        illegal;
        logic [4:0]  dest_index;
        logic [1:0]  wb_source;
        logic [31:0] wb_value;
        logic        mem_enable;
        logic        mem_is_load;
        logic [1:0]  mem_size_code;
        logic [31:0] mem_address;
        logic [31:0] store_data;
        logic        branch_taken;
        logic [31:0] next_pc;
    } exec_res_t;

    class exec_scoreboard;
        exec_res_t pending[$];
        int errors;
        int checked;

        static function logic [31:0] sdiv(logic [31:0] a, logic [31:0] b, bit want_rem);
            logic [31:0] ua;
            logic [31:0] ub;
            logic [31:0] r;
            ua = a[31] ? -a : a;
            ub = b[31] ? -b : b;
            if (b == 0)
                return 0;
            if (want_rem)
            begin
                r = ua % ub;
                return a[31] ? -r : r;
            end
            r = ua / ub;
            return (a[31] != b[31]) ? -r : r;
        endfunction

        function void note_word(logic [31:0] ins, logic [31:0] pc, logic [31:0] a,
                                logic [31:0] b);
            exec_res_t e;
            logic [6:0]  opc;
            logic [2:0]  f3;
            logic [6:0]  f7;
            logic [31:0] imm_i;
            logic [31:0] imm_s;
            logic [31:0] imm_b;
            logic [31:0] imm_j;
            logic [31:0] imm_u;
            logic [4:0]  sh;
            bit          ill;
            bit          c;
            opc = ins[6:0];
            f3 = ins[14:12];
            f7 = ins[31:25];
            imm_i = {{20{ins[31]}}, ins[31:20]};
            imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
            imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
            imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
            imm_u = {ins[31:12], 12'h000};
            sh = b[4:0];
            ill = 0;
            c = 0;
            e = '{default: 0};
            e.next_pc = pc + 4;
            case (opc)
                OPC_REG:
                begin
                    e.dest_index = ins[11:7];
                    e.wb_source = WB_ALU;
                    if (f7 == F7_BASE)
                        case (f3)
                            F3_ADD: e.wb_value = a + b;
                            F3_SLL: e.wb_value = a << sh;
                            F3_SLT: e.wb_value = ($signed(a) < $signed(b)) ? 1 : 0;
                            F3_XOR: e.wb_value = a ^ b;
                            F3_SRL: e.wb_value = a >> sh;
                            F3_OR:  e.wb_value = a | b;
                            F3_AND: e.wb_value = a & b;
                            default: ill = 1;
                        endcase
                    else if (f7 == F7_ALT)
                    begin
                        if (f3 == F3_ADD) e.wb_value = a - b;
                        else if (f3 == F3_SRL) e.wb_value = $signed(a) >>> sh;
                        else ill = 1;
                    end
                    else if (f7 == F7_MULDIV)
                    begin
                        if (f3 == F3_ADD) e.wb_value = a * b;
                        else if (f3 == F3_XOR) e.wb_value = sdiv(a, b, 0);
                        else if (f3 == F3_OR) e.wb_value = sdiv(a, b, 1);
                        else ill = 1;
                    end
                    else
                        ill = 1;
                end
                OPC_IMM:
                begin
                    e.dest_index = ins[11:7];
                    e.wb_source = WB_ALU;
                    if (f3 == F3_ADD) e.wb_value = a + imm_i;
                    else if (f3 == F3_AND) e.wb_value = a & imm_i;
                    else if (f3 == F3_OR) e.wb_value = a | imm_i;
                    else ill = 1;
                end
                OPC_LOAD:
                    if (f3 <= 3)
                    begin
                        e.dest_index = ins[11:7];
                        e.wb_source = WB_LOAD;
                        e.mem_enable = 1;
                        e.mem_is_load = 1;
                        e.mem_size_code = f3[1:0];
                        e.mem_address = a + imm_i;
                    end
                    else
                        ill = 1;
                OPC_STORE:
                    if (f3 <= 3)
                    begin
                        e.mem_enable = 1;
                        e.mem_size_code = f3[1:0];
                        e.mem_address = a + imm_s;
                        e.store_data = b;
                    end
                    else
                        ill = 1;
                OPC_JALR:
                    if (f3 == 0)
                    begin
                        e.dest_index = ins[11:7];
                        e.wb_source = WB_RET;
                        e.wb_value = pc + 4;
                        e.next_pc = (a + imm_i) & ~32'd1;
                    end
                    else
                        ill = 1;
                OPC_BRANCH:
                begin
                    if (f3 == F3_BEQ) c = (a == b);
                    else if (f3 == F3_BNE) c = (a != b);
                    else if (f3 == F3_BGE) c = !($signed(a) < $signed(b));
                    else if (f3 == F3_BLT) c = $signed(a) < $signed(b);
                    else ill = 1;
                    if (c)
                    begin
                        e.branch_taken = 1;
                        e.next_pc = pc + imm_b;
                    end
                end
                OPC_AUIPC:
                begin
                    e.dest_index = ins[11:7];
                    e.wb_source = WB_RET;
                    e.wb_value = pc + imm_u;
                end
                OPC_LUI:
                begin
                    e.dest_index = ins[11:7];
                    e.wb_source = WB_ALU;
                    e.wb_value = imm_u;
                end
                OPC_JAL:
                begin
                    e.dest_index = ins[11:7];
                    e.wb_source = WB_RET;
                    e.wb_value = pc + 4;
                    e.next_pc = pc + imm_j;
                end
                default: ill = 1;
            endcase
            if (ill)
            begin
                e = '{default: 0};
                e.illegal = 1;
                e.next_pc = pc + 4;
            end
            pending = {pending, e};
        endfunction

        function void check_word(exec_res_t got);
            exec_res_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result word", $time);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got !== e)
            begin
                errors++;
                $display("%0t: mismatch expected %p", $time, e);
                $display("%0t:          actual   %p", $time, got);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    logic [31:0] instr_word = 0;
    logic [31:0] cur_pc = 0;
    logic signed [31:0] src1_value = 0;
    logic signed [31:0] src2_value = 0;
    logic out_valid;
    logic out_stall = 0;
    logic illegal;
    logic [4:0] dest_index;
    logic [1:0] wb_source;
    logic [31:0] wb_value;
    logic mem_enable;
    logic mem_is_load;
    logic [1:0] mem_size_code;
    logic [31:0] mem_address;
    logic [31:0] store_data;
    logic branch_taken;
    logic [31:0] next_pc;

    exec_scoreboard sb = new();
    bit calm = 0;
    int idle_cycles = 0;

    always #4 clk = ~clk;

    rv32_subset_decode_execute_unit i_dut (.*);

    // sample both channels at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_word(instr_word, cur_pc, src1_value, src2_value);
        if (rst_n && out_valid && !out_stall)
            sb.check_word('{illegal, dest_index, wb_source, wb_value, mem_enable,
                            mem_is_load, mem_size_code, mem_address, store_data,
                            branch_taken, next_pc});
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > 2000)
        begin
            $display("watchdog: no progress");
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver stalls in bursts
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(1, 13);
                out_stall <= 1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 0;
        end
    end

    task automatic send_word(logic [31:0] ins, logic [31:0] pc, logic [31:0] a,
                             logic [31:0] b);
        int n;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            n = $urandom_range(1, 13);
            in_valid <= 0;
            repeat (n) @(negedge clk);
        end
        in_valid <= 1;
        instr_word <= ins;
        cur_pc <= pc;
        src1_value <= a;
        src2_value <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'hffff_ffff;
            2: return 0;
            3: return $urandom_range(0, 40);
            default: return $urandom;
        endcase
    endfunction

    // mostly supported encodings with random fields, some pure noise
    function automatic logic [31:0] pick_instr();
        logic [31:0] w;
        logic [6:0] opcs [9];
        opcs = '{OPC_REG, OPC_IMM, OPC_LOAD, OPC_JALR, OPC_STORE, OPC_BRANCH,
                 OPC_AUIPC, OPC_LUI, OPC_JAL};
        w = $urandom;
        if ($urandom_range(0, 9) == 0)
            return w;
        w[6:0] = opcs[$urandom_range(0, 8)];
        if (w[6:0] == OPC_REG && $urandom_range(0, 7) != 0)
            case ($urandom_range(0, 2))
                0: w[31:25] = F7_BASE;
                1: w[31:25] = F7_ALT;
                default: w[31:25] = F7_MULDIV;
            endcase
        return w;
    endfunction

    initial
    begin
        logic [31:0] dir [$];
        int t;
        dir = '{32'h0000_00b3, 32'h4000_00b3, 32'h0000_70b3, 32'h0000_60b3,
                32'h0000_40b3, 32'h0000_10b3, 32'h0000_50b3, 32'h4000_50b3,
                32'h0000_20b3, 32'h0200_00b3, 32'h0200_40b3, 32'h0200_60b3,
                32'hfff0_0093, 32'h8000_7093, 32'h7ff0_6093, 32'hfff0_3083,
                32'h8000_2023, 32'hfe00_0fe3, 32'h0000_1063, 32'h0000_5063,
                32'h8000_4063, 32'hfff0_00e7, 32'hffff_f0ef, 32'hffff_f097,
                32'hffff_f0b7};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        foreach (dir[k])
            send_word(dir[k], 32'hffff_fffc, 32'h8000_0000, 32'hffff_ffff);
        // zero divisor and plain illegal opcode
        send_word(32'h0200_40b3, 0, 5, 0);
        send_word(32'h0200_60b3, 0, 5, 0);
        send_word(32'hffff_ffff, 32'h1234, 7, 9);
        // drain fully before continuing
        in_valid <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        for (t = 0; t < 1050; t++)
        begin
            if (t == 900)
                calm = 1;
            send_word(pick_instr(), $urandom, pick_value(), pick_value());
        end
        in_valid <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        $display("covered directed decodes, div edge cases and %0d checked words",
                 sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/rvdx_pkg.sv
rtl/rvdx_div_pipe.sv
rtl/rv32_subset_decode_execute_unit.sv
test/tb_rv32_subset_decode_execute_unit.sv
